FILE: sv/wpp_pkg.sv
// ----------------------------------------------------------------------------
// wpp_pkg
// Shared types and constants of the WAV PCM byte stream parser.
// ----------------------------------------------------------------------------
package wpp_pkg;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // Error codes.
  typedef enum logic [2:0] {
    ERR_NOT_WAV      = 3'd0,
    ERR_BAD_CHANNELS = 3'd1,
    ERR_NOT_PCM      = 3'd2,
    ERR_BAD_BITS     = 3'd3,
    ERR_TRUNCATED    = 3'd4
  } err_code_t;

  // Parser phase. Codes without a member are handled as the skip phase.
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_SKIP   = 2'd2
  } phase_t;

  // Little-endian four-byte tags as they sit in the field shift register.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_LEN  = 32'd16;

  // Depth of the result queue; an item may push two results at once.
  localparam int QDEPTH = 4;
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] sample_value;
    logic               channel;
    logic [31:0]        sample_rate;
    logic [4:0]         bits_per_sample;
    logic [1:0]         channel_count;
    logic [31:0]        frame_count;
    err_code_t          error_code;
    logic               last;
  } result_t;

  // Results produced by one accepted item, in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } wpp_push_t;

endpackage

FILE: sv/wpp_in_if.sv
// ----------------------------------------------------------------------------
// wpp_in_if
// Byte input channel: one file byte per item with an end-of-file flag.
// ----------------------------------------------------------------------------
interface wpp_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

FILE: sv/wpp_out_if.sv
// ----------------------------------------------------------------------------
// wpp_out_if
// Result channel: header, sample or error items.
// ----------------------------------------------------------------------------
interface wpp_out_if ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] sample_value;
  logic               channel;
  logic [31:0]        sample_rate;
  logic [4:0]         bits_per_sample;
  logic [1:0]         channel_count;
  logic [31:0]        frame_count;
  logic [2:0]         error_code;
  logic               last;

  modport source (output valid, output kind, output sample_value, output channel,
                  output sample_rate, output bits_per_sample, output channel_count,
                  output frame_count, output error_code, output last, input ready);
  modport sink   (input valid, input kind, input sample_value, input channel,
                  input sample_rate, input bits_per_sample, input channel_count,
                  input frame_count, input error_code, input last, output ready);
endinterface

FILE: sv/wpp_out_queue.sv
// ----------------------------------------------------------------------------
// wpp_out_queue
// Shifting result queue that takes up to two results per cycle and hands out
// one; the head entry is the registered output.
// ----------------------------------------------------------------------------
module wpp_out_queue import wpp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  wpp_push_t push,
  output logic      room,
  output logic      head_valid,
  input  logic      head_ready,
  output result_t   head
);

  result_t          q_r   [QDEPTH];
  result_t          q_nxt [QDEPTH];
  logic [QCW-1:0]   count_r, count_nxt;
  logic [QCW-1:0]   base;
  logic             pop;

  assign pop        = head_valid && head_ready;
  assign head_valid = (count_r != '0);
  assign head       = q_r[0];
  // Room for two results, so a full item never has to be split.
  assign room       = (count_r <= QCW'(QDEPTH - 2));

  always_comb begin
    base      = count_r - QCW'(pop);
    count_nxt = base + QCW'(push.count);
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && (i < QDEPTH - 1)) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if ((push.count != 2'd0) && (QCW'(i) == base)) begin
        q_nxt[i] = push.first;
      end
      if ((push.count == 2'd2) && (QCW'(i) == base + QCW'(1))) begin
        q_nxt[i] = push.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

FILE: sv/wpp_parser.sv
// ----------------------------------------------------------------------------
// wpp_parser
// Header checker and sample decoder; turns one accepted byte into zero, one
// or two results.
// ----------------------------------------------------------------------------
module wpp_parser import wpp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  input  logic       stream_end,
  output wpp_push_t  push
);

  // Header byte positions at which a field is complete.
  localparam logic [5:0] IDX_RIFF  = 6'd3;
  localparam logic [5:0] IDX_WAVE  = 6'd11;
  localparam logic [5:0] IDX_FMT   = 6'd15;
  localparam logic [5:0] IDX_FLEN  = 6'd19;
  localparam logic [5:0] IDX_FMTID = 6'd21;
  localparam logic [5:0] IDX_CHANS = 6'd23;
  localparam logic [5:0] IDX_RATE  = 6'd27;
  localparam logic [5:0] IDX_BITS  = 6'd35;
  localparam logic [5:0] IDX_DATA  = 6'd39;
  localparam logic [5:0] IDX_LEN   = 6'd43;

  phase_t      phase_r, phase_nxt, phase_step;
  logic [5:0]  hdr_idx_r, hdr_idx_nxt;
  logic [31:0] field_shift_r, field_shift_nxt;
  logic        is_stereo_r, is_stereo_nxt;
  logic        is_wide_r, is_wide_nxt;
  logic [31:0] rate_hold_r, rate_hold_nxt;
  logic [31:0] samples_left_r, samples_left_nxt;
  logic [7:0]  low_byte_r, low_byte_nxt;
  logic        chan_tog_r, chan_tog_nxt;
  logic        byte_phase_r, byte_phase_nxt;

  logic [31:0] fs_in;
  logic [15:0] half;
  logic        hdr_bad;
  err_code_t   hdr_code;
  logic [1:0]  shift_amt;
  logic [31:0] frames;
  logic [31:0] samples_total;
  logic        sample_done;
  logic [31:0] samples_dec;
  logic        in_header, in_data, hdr_done;
  logic        trunc;
  result_t     main_res, trunc_res;
  logic        main_vld;

  assign fs_in         = {in_byte, field_shift_r[31:8]};
  assign half          = fs_in[31:16];
  assign shift_amt     = {1'b0, is_wide_r} + {1'b0, is_stereo_r};
  assign frames        = fs_in >> shift_amt;
  assign samples_total = is_stereo_r ? {frames[30:0], 1'b0} : frames;
  assign sample_done   = !is_wide_r || byte_phase_r;
  assign samples_dec   = samples_left_r - 32'd1;
  assign in_header     = (phase_r == PH_HEADER);
  assign in_data       = (phase_r == PH_DATA);
  assign hdr_done      = in_header && !hdr_bad && (hdr_idx_r == IDX_LEN);

  // Field checks, judged on the last byte of each field.
  always_comb begin
    hdr_bad  = 1'b0;
    hdr_code = ERR_NOT_WAV;
    unique case (hdr_idx_r)
      IDX_RIFF:  hdr_bad = (fs_in != TAG_RIFF);
      IDX_WAVE:  hdr_bad = (fs_in != TAG_WAVE);
      IDX_FMT:   hdr_bad = (fs_in != TAG_FMT);
      IDX_FLEN:  hdr_bad = (fs_in != FMT_LEN);
      IDX_FMTID: begin
        hdr_bad  = (half != 16'd1);
        hdr_code = ERR_NOT_PCM;
      end
      IDX_CHANS: begin
        hdr_bad  = (half != 16'd1) && (half != 16'd2);
        hdr_code = ERR_BAD_CHANNELS;
      end
      IDX_BITS: begin
        hdr_bad  = (half != 16'd8) && (half != 16'd16);
        hdr_code = ERR_BAD_BITS;
      end
      IDX_DATA:  hdr_bad = (fs_in != TAG_DATA);
      default:   hdr_bad = 1'b0;
    endcase
  end

  // Next phase.
  always_comb begin
    phase_step = phase_r;
    unique case (phase_r)
      PH_HEADER: begin
        if (hdr_bad) begin
          phase_step = PH_SKIP;
        end else if (hdr_idx_r == IDX_LEN) begin
          phase_step = (samples_total == '0) ? PH_SKIP : PH_DATA;
        end else if (hdr_idx_r > IDX_LEN) begin
          phase_step = PH_SKIP;
        end
      end
      PH_DATA: begin
        if (sample_done && (samples_dec == '0)) begin
          phase_step = PH_SKIP;
        end
      end
      default: phase_step = PH_SKIP;
    endcase
    phase_nxt = phase_r;
    if (in_fire) begin
      phase_nxt = stream_end ? PH_HEADER : phase_step;
    end
  end

  // Datapath registers.
  always_comb begin
    hdr_idx_nxt      = hdr_idx_r;
    field_shift_nxt  = field_shift_r;
    is_stereo_nxt    = is_stereo_r;
    is_wide_nxt      = is_wide_r;
    rate_hold_nxt    = rate_hold_r;
    samples_left_nxt = samples_left_r;
    low_byte_nxt     = low_byte_r;
    chan_tog_nxt     = chan_tog_r;
    byte_phase_nxt   = byte_phase_r;
    if (in_fire) begin
      if (in_header) begin
        field_shift_nxt = fs_in;
        hdr_idx_nxt     = hdr_idx_r + 6'd1;
        if (!hdr_bad) begin
          if (hdr_idx_r == IDX_CHANS) begin
            is_stereo_nxt = (half == 16'd2);
          end
          if (hdr_idx_r == IDX_RATE) begin
            rate_hold_nxt = fs_in;
          end
          if (hdr_idx_r == IDX_BITS) begin
            is_wide_nxt = (half == 16'd16);
          end
          if (hdr_idx_r == IDX_LEN) begin
            samples_left_nxt = samples_total;
            chan_tog_nxt     = 1'b0;
            byte_phase_nxt   = 1'b0;
          end
        end
      end else if (in_data) begin
        if (!sample_done) begin
          low_byte_nxt   = in_byte;
          byte_phase_nxt = 1'b1;
        end else begin
          byte_phase_nxt   = 1'b0;
          samples_left_nxt = samples_dec;
          chan_tog_nxt     = chan_tog_r ^ is_stereo_r;
        end
      end
      if (stream_end) begin
        hdr_idx_nxt      = '0;
        field_shift_nxt  = '0;
        is_stereo_nxt    = 1'b0;
        is_wide_nxt      = 1'b0;
        rate_hold_nxt    = '0;
        samples_left_nxt = '0;
        low_byte_nxt     = '0;
        chan_tog_nxt     = 1'b0;
        byte_phase_nxt   = 1'b0;
      end
    end
  end

  // Results of this byte.
  always_comb begin
    main_res  = result_t'('0);
    trunc_res = result_t'('0);
    main_vld  = 1'b0;
    if (in_header && hdr_bad) begin
      main_vld            = 1'b1;
      main_res.kind       = KIND_ERROR;
      main_res.error_code = hdr_code;
      main_res.last       = 1'b1;
    end else if (hdr_done) begin
      main_vld                 = 1'b1;
      main_res.kind            = KIND_HEADER;
      main_res.sample_rate     = rate_hold_r;
      main_res.bits_per_sample = is_wide_r ? 5'd16 : 5'd8;
      main_res.channel_count   = is_stereo_r ? 2'd2 : 2'd1;
      main_res.frame_count     = frames;
      main_res.last            = (samples_total == '0);
    end else if (in_data && sample_done) begin
      main_vld              = 1'b1;
      main_res.kind         = KIND_SAMPLE;
      main_res.sample_value = is_wide_r ? {in_byte, low_byte_r}
                                        : {{8{~in_byte[7]}}, ~in_byte[7], in_byte[6:0]};
      main_res.channel      = is_stereo_r & chan_tog_r;
      main_res.last         = (samples_dec == '0);
    end
    trunc = stream_end && ((phase_step == PH_HEADER) || (phase_step == PH_DATA));
    trunc_res.kind       = KIND_ERROR;
    trunc_res.error_code = ERR_TRUNCATED;
    trunc_res.last       = 1'b1;

    push = wpp_push_t'('0);
    if (in_fire) begin
      if (main_vld) begin
        push.first  = main_res;
        push.second = trunc_res;
        push.count  = trunc ? 2'd2 : 2'd1;
      end else if (trunc) begin
        push.first = trunc_res;
        push.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      hdr_idx_r      <= '0;
      field_shift_r  <= '0;
      is_stereo_r    <= 1'b0;
      is_wide_r      <= 1'b0;
      rate_hold_r    <= '0;
      samples_left_r <= '0;
      low_byte_r     <= '0;
      chan_tog_r     <= 1'b0;
      byte_phase_r   <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      hdr_idx_r      <= hdr_idx_nxt;
      field_shift_r  <= field_shift_nxt;
      is_stereo_r    <= is_stereo_nxt;
      is_wide_r      <= is_wide_nxt;
      rate_hold_r    <= rate_hold_nxt;
      samples_left_r <= samples_left_nxt;
      low_byte_r     <= low_byte_nxt;
      chan_tog_r     <= chan_tog_nxt;
      byte_phase_r   <= byte_phase_nxt;
    end
  end

endmodule

FILE: sv/wav_pcm_stream_parser.sv
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser
// Byte-serial parser for RIFF WAVE files holding 8- or 16-bit PCM audio.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Item contents
//   in_chan   in         valid / ready  in_byte, stream_end
//   out_chan  out        valid / ready  kind, sample_value, channel,
//                                       sample_rate, bits_per_sample,
//                                       channel_count, frame_count,
//                                       error_code, last
//
// One byte item is accepted per cycle while the queue has room. Each byte is
// decoded in the cycle it is accepted and its results land in a four-entry
// result queue, whose head is the registered output. A byte may produce two
// results (a header or sample followed by a truncation error); the queue then
// drains them one per cycle while the output is ready. in_chan.ready
// is high while the queue has room for two results, so with the output
// taking one result per cycle the input never stalls. Reset (rst_n low,
// synchronous) returns the parser to the start of a header and empties the
// queue.
//
// The header is checked field by field in strict order, every field judged
// on its last byte. A failing field reports one error item with last set;
// the following bytes are dropped until stream_end, which always returns the
// parser to the start of a new file. After the 44-byte header, samples are
// emitted with the channel alternating for stereo files.
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser import wpp_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  wpp_in_if.sink  in_chan,
  wpp_out_if.source out_chan
);

  wpp_push_t push;
  logic      room;
  logic      in_fire;
  result_t   head;

  assign in_chan.ready = room;
  assign in_fire       = in_chan.valid && room;

  // Header checks, sample assembly and the parse state.
  wpp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_byte    (in_chan.in_byte),
    .stream_end (in_chan.stream_end),
    .push       (push)
  );

  // Result queue; its head drives the output channel directly.
  wpp_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (out_chan.valid),
    .head_ready (out_chan.ready),
    .head       (head)
  );

  assign out_chan.kind            = head.kind;
  assign out_chan.sample_value    = head.sample_value;
  assign out_chan.channel         = head.channel;
  assign out_chan.sample_rate     = head.sample_rate;
  assign out_chan.bits_per_sample = head.bits_per_sample;
  assign out_chan.channel_count   = head.channel_count;
  assign out_chan.frame_count     = head.frame_count;
  assign out_chan.error_code      = head.error_code;
  assign out_chan.last            = head.last;

endmodule

FILE: tb/wav_pcm_stream_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser_test
// Self-checking bench for the byte-serial RIFF WAVE PCM parser. WAV files,
// whole, broken, cut short or plain noise, are fed one byte per item. A
// behavioral decoder in the bench computes the results each accepted byte
// owes, and every result item the parser emits is checked against them.
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser_test;
  import wpp_pkg::*;

  // Description of one file to send. Tags and header fields are the raw
  // values placed in the header, so any of them may be made wrong on purpose.
  typedef struct {
    logic [31:0] riff_tag;
    logic [31:0] wave_tag;
    logic [31:0] fmt_tag;
    logic [31:0] data_tag;
    logic [31:0] fmt_len;
    logic [31:0] rate;
    logic [31:0] data_len;
    logic [15:0] format;
    logic [15:0] chans;
    logic [15:0] bits;
    int          data_bytes;   // sample bytes actually sent after the header
    int          extra_bytes;  // trailing bytes after the sample bytes
    int          cut_at;       // index of the byte carrying stream_end, -1: none
    int          noise_len;    // nonzero: send that many random bytes instead
    bit          extremes;     // sample bytes cycle 00, 80, FF, 7F
  } wav_spec_t;

  localparam int NUM_DIRECTED = 16;

  logic clk;
  logic rst_n;

  wpp_in_if  in_chan ();
  wpp_out_if out_chan ();

  wav_pcm_stream_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Travels with each byte item: on the first byte of a directed file it
  // says that the file's first result is the typed-in one from the table.
  logic    in_first_typed;
  result_t in_typed_want;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int bytes_sent     = 0;
  int fail_count     = 0;

  logic [7:0] file_bytes [$];
  result_t    owed_results [$];

  // Decoder state, kept in the same shape as the parser's own.
  phase_t      parse_phase;
  logic [5:0]  hdr_idx;
  logic [31:0] field_shift;
  logic        stereo;
  logic        wide;
  logic [31:0] rate_hold;
  logic [31:0] samples_left;
  logic [7:0]  low_hold;
  logic        chan_toggle;
  logic        byte_phase;

  // When set, the next result the decoder owes is replaced by typed_pending.
  bit      typed_armed;
  result_t typed_pending;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous limit: the slowest correct run needs well under a tenth of it.
  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result receiver: stalls at random at the rate of the current phase.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ------------------------------------------------------------------------
  // Result builders, shared by the decoder and the directed table.
  // ------------------------------------------------------------------------
  function automatic result_t err_result(err_code_t code);
    result_t r;
    r = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic result_t hdr_result(logic [31:0] rate, logic [4:0] bits,
                                         logic [1:0] chans, logic [31:0] frames,
                                         logic last);
    result_t r;
    r = '0;
    r.kind            = KIND_HEADER;
    r.sample_rate     = rate;
    r.bits_per_sample = bits;
    r.channel_count   = chans;
    r.frame_count     = frames;
    r.last            = last;
    return r;
  endfunction

  function automatic result_t smp_result(logic [15:0] value, logic chan, logic last);
    result_t r;
    r = '0;
    r.kind         = KIND_SAMPLE;
    r.sample_value = value;
    r.channel      = chan;
    r.last         = last;
    return r;
  endfunction

  function automatic string show(result_t r);
    return $sformatf({"kind=%0d sample=%0d ch=%0d rate=%0d bits=%0d chans=%0d",
                      " frames=%0d err=%0d last=%0d"},
                     r.kind, r.sample_value, r.channel, r.sample_rate, r.bits_per_sample,
                     r.channel_count, r.frame_count, r.error_code, r.last);
  endfunction

  function automatic bit same_result(result_t a, result_t b);
    return a.kind === b.kind && a.sample_value === b.sample_value &&
           a.channel === b.channel && a.sample_rate === b.sample_rate &&
           a.bits_per_sample === b.bits_per_sample &&
           a.channel_count === b.channel_count && a.frame_count === b.frame_count &&
           a.error_code === b.error_code && a.last === b.last;
  endfunction

  // Only the first ten failures are printed; all of them are counted.
  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // ------------------------------------------------------------------------
  // Decoder
  // ------------------------------------------------------------------------
  function automatic void restart_parse();
    parse_phase  = PH_HEADER;
    hdr_idx      = '0;
    field_shift  = '0;
    stereo       = 1'b0;
    wide         = 1'b0;
    rate_hold    = '0;
    samples_left = '0;
    low_hold     = '0;
    chan_toggle  = 1'b0;
    byte_phase   = 1'b0;
  endfunction

  function automatic void owe_result(result_t r);
    if (typed_armed) begin
      owed_results.push_back(typed_pending);
      typed_armed = 1'b0;
    end else begin
      owed_results.push_back(r);
    end
  endfunction

  // Works out the results that one accepted byte causes.
  function automatic void decode_byte(logic [7:0] b, logic eop);
    logic [5:0]  idx;
    logic [15:0] half;
    logic [31:0] frames;
    logic [15:0] value;
    logic        failed;
    err_code_t   code;
    failed = 1'b0;
    code   = ERR_NOT_WAV;
    if (parse_phase == PH_HEADER) begin
      idx         = hdr_idx;
      field_shift = {b, field_shift[31:8]};
      half        = field_shift[31:16];
      hdr_idx     = idx + 6'd1;
      // Every field is judged on its last byte, in file order.
      case (idx)
        6'd3:  failed = (field_shift != TAG_RIFF);
        6'd11: failed = (field_shift != TAG_WAVE);
        6'd15: failed = (field_shift != TAG_FMT);
        6'd19: failed = (field_shift != FMT_LEN);
        6'd21: begin
          if (half != 16'd1) begin
            failed = 1'b1;
            code   = ERR_NOT_PCM;
          end
        end
        6'd23: begin
          if (half != 16'd1 && half != 16'd2) begin
            failed = 1'b1;
            code   = ERR_BAD_CHANNELS;
          end else begin
            stereo = (half == 16'd2);
          end
        end
        6'd27: rate_hold = field_shift;
        6'd35: begin
          if (half != 16'd8 && half != 16'd16) begin
            failed = 1'b1;
            code   = ERR_BAD_BITS;
          end else begin
            wide = (half == 16'd16);
          end
        end
        6'd39: failed = (field_shift != TAG_DATA);
        6'd43: begin
          // Frame count truncates; a data length under one frame owes no samples.
          frames       = field_shift >> ({1'b0, wide} + {1'b0, stereo});
          samples_left = frames << stereo;
          owe_result(hdr_result(rate_hold, wide ? 5'd16 : 5'd8, stereo ? 2'd2 : 2'd1,
                                frames, samples_left == 32'd0));
          parse_phase = (samples_left == 32'd0) ? PH_SKIP : PH_DATA;
          chan_toggle = 1'b0;
          byte_phase  = 1'b0;
        end
        default: if (idx > 6'd43) parse_phase = PH_SKIP;
      endcase
      // A failing field reports alone, even on the byte that ends the file.
      if (failed) begin
        owe_result(err_result(code));
        parse_phase = PH_SKIP;
        if (eop) restart_parse();
        return;
      end
    end else if (parse_phase == PH_DATA) begin
      if (wide && !byte_phase) begin
        low_hold   = b;
        byte_phase = 1'b1;
      end else begin
        value        = wide ? {b, low_hold} : ({8'h00, b} - 16'd128);
        byte_phase   = 1'b0;
        samples_left = samples_left - 32'd1;
        owe_result(smp_result(value, stereo & chan_toggle, samples_left == 32'd0));
        if (stereo) chan_toggle = ~chan_toggle;
        if (samples_left == 32'd0) parse_phase = PH_SKIP;
      end
    end
    // Ending inside the header or with samples still owed is a truncation.
    if (eop) begin
      if (parse_phase == PH_HEADER || parse_phase == PH_DATA)
        owe_result(err_result(ERR_TRUNCATED));
      restart_parse();
    end
  endfunction

  // ------------------------------------------------------------------------
  // Checker. Expectations are added on input acceptance and taken on output
  // acceptance in the same process, so the order within an edge is fixed.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      restart_parse();
      typed_armed = 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        if (in_first_typed) begin
          typed_armed   = 1'b1;
          typed_pending = in_typed_want;
        end
        decode_byte(in_chan.in_byte, in_chan.stream_end);
      end
      if (out_chan.valid && out_chan.ready) begin
        got.kind            = kind_t'(out_chan.kind);
        got.sample_value    = out_chan.sample_value;
        got.channel         = out_chan.channel;
        got.sample_rate     = out_chan.sample_rate;
        got.bits_per_sample = out_chan.bits_per_sample;
        got.channel_count   = out_chan.channel_count;
        got.frame_count     = out_chan.frame_count;
        got.error_code      = err_code_t'(out_chan.error_code);
        got.last            = out_chan.last;
        if (owed_results.size() == 0) begin
          note_failure({"unexpected result: ", show(got)});
        end else begin
          want = owed_results.pop_front();
          if (!same_result(got, want))
            note_failure({"mismatch: expected ", show(want), " actual ", show(got)});
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------
  function automatic wav_spec_t std_spec(int chans, int bits, int frames);
    wav_spec_t s;
    s.riff_tag    = TAG_RIFF;
    s.wave_tag    = TAG_WAVE;
    s.fmt_tag     = TAG_FMT;
    s.data_tag    = TAG_DATA;
    s.fmt_len     = FMT_LEN;
    s.format      = 16'd1;
    s.chans       = 16'(chans);
    s.bits        = 16'(bits);
    s.rate        = 32'd44100;
    s.data_len    = 32'(frames * chans * (bits / 8));
    s.data_bytes  = frames * chans * (bits / 8);
    s.extra_bytes = 0;
    s.cut_at      = -1;
    s.noise_len   = 0;
    s.extremes    = 1'b0;
    return s;
  endfunction

  function automatic void put_le(logic [31:0] v, int n);
    for (int k = 0; k < n; k++) file_bytes.push_back(v[8*k +: 8]);
  endfunction

  // Lays out the 44-byte header, the sample bytes and any trailing bytes.
  // The byte rate, block align and RIFF length are random, as they are read
  // but never checked.
  function automatic void build_file(wav_spec_t s);
    file_bytes.delete();
    put_le(s.riff_tag, 4);
    put_le($urandom, 4);
    put_le(s.wave_tag, 4);
    put_le(s.fmt_tag, 4);
    put_le(s.fmt_len, 4);
    put_le({16'd0, s.format}, 2);
    put_le({16'd0, s.chans}, 2);
    put_le(s.rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le({16'd0, s.bits}, 2);
    put_le(s.data_tag, 4);
    put_le(s.data_len, 4);
    for (int k = 0; k < s.data_bytes; k++) begin
      if (s.extremes) begin
        case (k % 4)
          0:       file_bytes.push_back(8'h00);
          1:       file_bytes.push_back(8'h80);
          2:       file_bytes.push_back(8'hFF);
          default: file_bytes.push_back(8'h7F);
        endcase
      end else begin
        file_bytes.push_back(8'($urandom));
      end
    end
    for (int k = 0; k < s.extra_bytes; k++) file_bytes.push_back(8'($urandom));
    if (s.cut_at >= 0 && s.cut_at < file_bytes.size())
      file_bytes = file_bytes[0:s.cut_at];
  endfunction

  // Most random files are well formed so the sample path is well exercised;
  // the rest have one broken field, are cut short, or are noise.
  function automatic wav_spec_t random_spec();
    wav_spec_t   s;
    int          pick;
    int          frame_bytes;
    int          end_idx;
    logic [31:0] flip;
    s = std_spec($urandom_range(1, 2), $urandom_range(1) ? 16 : 8, $urandom_range(0, 6));
    case ($urandom_range(9))
      0:       s.rate = 32'd0;
      1:       s.rate = 32'hFFFF_FFFF;
      default: s.rate = $urandom;
    endcase
    frame_bytes = s.chans * (s.bits / 8);
    pick        = $urandom_range(99);
    flip        = 32'd1 << $urandom_range(31);
    end_idx     = 0;
    if (pick < 55) begin
      // A partial frame at the end of the data becomes trailing bytes.
      s.data_len    = s.data_len + $urandom_range(frame_bytes - 1);
      s.data_bytes  = s.data_len;
      s.extra_bytes = $urandom_range(3);
      s.extremes    = ($urandom_range(9) == 0);
    end else if (pick < 65) begin
      // Huge data length with only a few bytes sent: ends owing samples.
      s.data_len   = $urandom;
      s.data_bytes = $urandom_range(12);
    end else if (pick < 80) begin
      case ($urandom_range(7))
        0: begin s.riff_tag ^= flip; end_idx = 3;  end
        1: begin s.wave_tag ^= flip; end_idx = 11; end
        2: begin s.fmt_tag  ^= flip; end_idx = 15; end
        3: begin s.fmt_len  ^= flip; end_idx = 19; end
        4: begin s.format ^= 16'd1 << $urandom_range(15); end_idx = 21; end
        5: begin
          s.chans = 16'($urandom);
          if (s.chans == 16'd1 || s.chans == 16'd2) s.chans += 16'd2;
          end_idx = 23;
        end
        6: begin
          s.bits = 16'($urandom);
          if (s.bits == 16'd8 || s.bits == 16'd16) s.bits += 16'd1;
          end_idx = 35;
        end
        default: begin s.data_tag ^= flip; end_idx = 39; end
      endcase
      // Sometimes the file also ends on the failing byte itself.
      if ($urandom_range(2) == 0) s.cut_at = end_idx;
    end else if (pick < 92) begin
      s.cut_at = $urandom_range(43 + s.data_bytes);
    end else begin
      s.noise_len = $urandom_range(1, 24);
    end
    return s;
  endfunction

  task automatic send_byte(logic [7:0] b, logic eop, logic typed, result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.in_byte    <= b;
    in_chan.stream_end <= eop;
    in_first_typed     <= typed;
    in_typed_want      <= want;
    do @(posedge clk); while (!in_chan.ready);
    bytes_sent++;
  endtask

  task automatic send_file(wav_spec_t s, logic typed, result_t want);
    if (s.noise_len > 0) begin
      // Noise may end the file anywhere, which restarts header parsing.
      for (int k = 0; k < s.noise_len; k++)
        send_byte(8'($urandom), k == s.noise_len - 1 || $urandom_range(9) == 0,
                  1'b0, want);
    end else begin
      build_file(s);
      for (int k = 0; k < file_bytes.size(); k++)
        send_byte(file_bytes[k], k == file_bytes.size() - 1, typed && k == 0, want);
    end
  endtask

  // Holds the sender off until every owed result has come out. Ends at a
  // falling edge; anything still owed after a long wait is a failure.
  task automatic await_drain();
    int waited;
    waited = 0;
    in_chan.valid <= 1'b0;
    do begin
      @(negedge clk);
      waited++;
    end while (owed_results.size() != 0 && waited < 5000);
    if (owed_results.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", owed_results.size()));
      owed_results.delete();
    end
  endtask

  initial begin
    wav_spec_t dir_spec [NUM_DIRECTED];
    bit        dir_typed [NUM_DIRECTED];
    result_t   dir_want [NUM_DIRECTED];
    int        phase_start;
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.in_byte    = 8'h00;
    in_chan.stream_end = 1'b0;
    in_first_typed     = 1'b0;
    in_typed_want      = '0;

    // Directed files. Where the first result can be read straight off the
    // row it is typed in; every other result comes from the decoder.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      dir_spec[i]  = std_spec(1, 8, 2);
      dir_typed[i] = 1'b0;
      dir_want[i]  = '0;
    end
    // Each checked field before the data tag broken in turn, judged on its last byte.
    dir_spec[0].riff_tag = TAG_RIFF ^ 32'h0100_0000;
    dir_spec[1].wave_tag = TAG_WAVE ^ 32'h0000_0020;
    dir_spec[2].fmt_tag  = TAG_FMT ^ 32'h8000_0000;
    dir_spec[3].fmt_len  = 32'd18;
    dir_spec[4].format   = 16'd3;
    dir_spec[5].chans    = 16'd0;
    dir_spec[6].chans    = 16'hFFFF;
    dir_spec[7].bits     = 16'd24;
    dir_spec[15].bits    = 16'hFFFF;
    // Each broken file ends one byte after its failing field; that byte is dropped.
    dir_spec[0].cut_at  = 4;
    dir_spec[1].cut_at  = 12;
    dir_spec[2].cut_at  = 16;
    dir_spec[3].cut_at  = 20;
    dir_spec[4].cut_at  = 22;
    dir_spec[5].cut_at  = 24;
    dir_spec[6].cut_at  = 24;
    dir_spec[7].cut_at  = 36;
    dir_spec[15].cut_at = 36;
    for (int i = 0; i <= 3; i++) dir_want[i] = err_result(ERR_NOT_WAV);
    dir_want[4]  = err_result(ERR_NOT_PCM);
    dir_want[5]  = err_result(ERR_BAD_CHANNELS);
    dir_want[6]  = err_result(ERR_BAD_CHANNELS);
    dir_want[7]  = err_result(ERR_BAD_BITS);
    dir_want[15] = err_result(ERR_BAD_BITS);
    // Broken data tag on the very byte that ends the file: no truncation.
    dir_spec[8].data_tag = TAG_DATA ^ 32'h0000_0100;
    dir_spec[8].cut_at   = 39;
    dir_want[8]          = err_result(ERR_NOT_WAV);
    // File ends on its first byte.
    dir_spec[9].cut_at = 0;
    dir_want[9]        = err_result(ERR_TRUNCATED);
    // Data shorter than one frame, then trailing bytes that are dropped.
    dir_spec[10]             = std_spec(1, 16, 0);
    dir_spec[10].data_len    = 32'd1;
    dir_spec[10].data_bytes  = 1;
    dir_spec[10].extra_bytes = 3;
    dir_want[10] = hdr_result(32'd44100, 5'd16, 2'd1, 32'd0, 1'b1);
    for (int i = 0; i <= 10; i++) dir_typed[i] = 1'b1;
    dir_typed[15] = 1'b1;
    // Sample extremes in both widths, with rate extremes alongside.
    dir_spec[11]             = std_spec(1, 8, 8);
    dir_spec[11].rate        = 32'd0;
    dir_spec[11].extremes    = 1'b1;
    dir_spec[11].extra_bytes = 2;
    dir_spec[12]             = std_spec(2, 16, 3);
    dir_spec[12].rate        = 32'hFFFF_FFFF;
    dir_spec[12].extremes    = 1'b1;
    // Largest data length, ending between the two bytes of a sample.
    dir_spec[13]            = std_spec(2, 16, 0);
    dir_spec[13].data_len   = 32'hFFFF_FFFF;
    dir_spec[13].data_bytes = 5;
    // Header result and a truncation on the same byte.
    dir_spec[14]        = std_spec(2, 8, 2);
    dir_spec[14].cut_at = 43;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) send_file(dir_spec[i], dir_typed[i], dir_want[i]);
    await_drain();

    // Random files in four pressure phases, each drained before the next.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      @(posedge clk);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 40) send_file(random_spec(), 1'b0, '0);
      await_drain();
    end

    // Leave time for any stray result to show up before the verdict.
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
